FILE: hdl/bfsp_pkg.sv
package bfsp_pkg;

   // Field widths fixed by the interface
   localparam int VERTEX_W    = 5;
   localparam int WEIGHT_IN_W = 16;
   localparam int DIST_W      = 32;
   localparam int VCOUNT_W    = 6;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_VERTEX = 2'd1;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;
   localparam logic [VERTEX_W-1:0] SOURCE_RESET = 5'd0;

   // Saturation limits of the distance
   localparam logic [DIST_W-1:0] DIST_MAX = 32'h7fff_ffff;
   localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [VERTEX_W-1:0]           edge_source;
      logic [VERTEX_W-1:0]           edge_dest;
      logic signed [WEIGHT_IN_W-1:0] edge_weight;
      logic                          last_edge;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0]      vertex_index;
      logic                     reachable;
      logic signed [DIST_W-1:0] distance;
      logic                     negative_cycle;
      logic                     edge_overflow;
      logic                     last_result;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic idle;
      logic start;
      logic clr_write;
      logic pass_init;
      logic edge_rd;
      logic dist_rd;
      logic relax;
      logic pass_next;
      logic out_rd;
      logic out_load;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_req;
      logic nv_zero;
      logic vidx_last;
      logic edges_empty;
      logic edge_last;
      logic pass_check;
      logic rsp_free;
   } sts_type;

endpackage

FILE: hdl/bfsp_ram.sv
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bfsp_ctrl.sv
module bfsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  bfsp_pkg::sts_type sts,
   output bfsp_pkg::cmd_type cmd
);

   import bfsp_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      CLEAR,
      EDGE_RD,
      DIST_RD,
      RELAX,
      OUT_RD,
      OUT_WAIT
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            cmd.idle = 1'b1;
            if (sts.start_req) begin
               if (sts.nv_zero) begin
                  cmd.finish = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = CLEAR;
               end
            end
         end
         CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.vidx_last) begin
               if (sts.edges_empty) begin
                  state_in = OUT_RD;
               end else begin
                  cmd.pass_init = 1'b1;
                  state_in      = EDGE_RD;
               end
            end
         end
         EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = DIST_RD;
         end
         DIST_RD: begin
            cmd.dist_rd = 1'b1;
            state_in    = RELAX;
         end
         RELAX: begin
            cmd.relax = 1'b1;
            if (sts.edge_last) begin
               cmd.pass_next = 1'b1;
               state_in      = sts.pass_check ? OUT_RD : EDGE_RD;
            end else begin
               state_in = DIST_RD;
            end
         end
         OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = OUT_WAIT;
         end
         OUT_WAIT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               if (sts.vidx_last) begin
                  cmd.finish = 1'b1;
                  state_in   = IDLE;
               end else begin
                  state_in = OUT_RD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/bfsp_dp.sv
module bfsp_dp #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bfsp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bfsp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bfsp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  bfsp_pkg::cmd_type                    cmd,
   output bfsp_pkg::sts_type                    sts
);

   import bfsp_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int NV_W   = $clog2(MAX_VERTICES + 1);
   localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int CW     = (NV_W > VCOUNT_W) ? NV_W : VCOUNT_W;
   localparam int EDGE_W = 2 * VERTEX_W + WEIGHT_BITS;
   localparam int DENT_W = DIST_W + 1;

   // Control state
   logic [VCOUNT_W-1:0] vcount_ff;
   logic [VERTEX_W-1:0] source_ff;
   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic                ovf_ff, ovf_in;
   logic [NV_W-1:0]     nv_ff, nv_in;
   logic [VIDX_W-1:0]   vidx_ff, vidx_in;
   logic [EIDX_W-1:0]   eidx_ff, eidx_in;
   logic [NV_W-1:0]     pass_ff, pass_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   // Datapath wiring
   logic                accept;
   logic                room;
   logic [31:0]         weight_raw;
   logic [EDGE_W-1:0]   edge_wr_data;
   logic                edge_rd_en;
   logic [EIDX_W-1:0]   edge_rd_addr;
   logic [EDGE_W-1:0]   edge_q;
   logic [VERTEX_W-1:0] e_from, e_to;
   logic [WEIGHT_BITS-1:0] e_w;
   logic                dist_wr_en;
   logic [VIDX_W-1:0]   dist_wr_addr;
   logic [DENT_W-1:0]   dist_wr_data;
   logic                dist_a_rd_en;
   logic [VIDX_W-1:0]   dist_a_addr;
   logic [DENT_W-1:0]   dist_a_q, dist_b_q;
   logic signed [DIST_W-1:0] dist_u, dist_v, sum_sat;
   logic [DENT_W-1:0]   sum_wide;
   logic [DENT_W-1:0]   w_ext;
   logic                apply;
   logic                relax_hit;
   logic [CW-1:0]       vcount_ext;

   assign csr_ready = 1'b1;
   assign req_stall = ~cmd.idle;
   assign accept    = req_valid & cmd.idle;
   assign room      = (loaded_ff != CNT_W'(MAX_EDGES));

   // Effective vertex count, capped at the store size
   assign vcount_ext = CW'(vcount_ff);
   assign nv_in = (vcount_ext > CW'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : NV_W'(vcount_ff);

   // Edge store: beat written at the fill count, weight cut to WEIGHT_BITS
   assign weight_raw   = {{(32 - WEIGHT_IN_W){1'b0}}, req_data.edge_weight};
   assign edge_wr_data = {req_data.edge_source, req_data.edge_dest,
                          weight_raw[WEIGHT_BITS-1:0]};
   assign edge_rd_en   = cmd.edge_rd | (cmd.relax & ~sts.edge_last);
   assign edge_rd_addr = cmd.edge_rd ? eidx_ff : eidx_ff + EIDX_W'(1);

   bfsp_ram #(
      .WIDTH(EDGE_W),
      .DEPTH(MAX_EDGES)
   ) u_edge_ram (
      .clock  (clock),
      .wr_en  (accept & room),
      .wr_addr(loaded_ff[EIDX_W-1:0]),
      .wr_data(edge_wr_data),
      .rd_en  (edge_rd_en),
      .rd_addr(edge_rd_addr),
      .rd_data(edge_q)
   );

   assign e_w    = edge_q[WEIGHT_BITS-1:0];
   assign e_to   = edge_q[WEIGHT_BITS +: VERTEX_W];
   assign e_from = edge_q[WEIGHT_BITS + VERTEX_W +: VERTEX_W];

   // Relaxation: saturating sum of source distance and weight
   assign dist_u   = dist_a_q[DIST_W-1:0];
   assign dist_v   = dist_b_q[DIST_W-1:0];
   assign w_ext    = {{(DENT_W - WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w};
   assign sum_wide = {dist_u[DIST_W-1], dist_u} + w_ext;
   always_comb begin
      if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
         sum_sat = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         sum_sat = sum_wide[DIST_W-1:0];
      end
   end

   assign apply     = (pass_ff != '0);
   assign relax_hit = (CW'(e_from) < CW'(nv_ff)) && (CW'(e_to) < CW'(nv_ff))
                      && dist_a_q[DIST_W] && (!dist_b_q[DIST_W] || dist_v > sum_sat);

   // Distance store: two copies give the two read ports
   always_comb begin
      if (cmd.clr_write) begin
         dist_wr_en   = 1'b1;
         dist_wr_addr = vidx_ff;
         dist_wr_data = {(CW'(vidx_ff) == CW'(source_ff)), {DIST_W{1'b0}}};
      end else begin
         dist_wr_en   = cmd.relax & relax_hit & apply;
         dist_wr_addr = VIDX_W'(e_to);
         dist_wr_data = {1'b1, sum_sat};
      end
   end

   assign dist_a_rd_en = cmd.dist_rd | cmd.out_rd;
   assign dist_a_addr  = cmd.out_rd ? vidx_ff : VIDX_W'(e_from);

   bfsp_ram #(
      .WIDTH(DENT_W),
      .DEPTH(MAX_VERTICES)
   ) u_dist_ram_a (
      .clock  (clock),
      .wr_en  (dist_wr_en),
      .wr_addr(dist_wr_addr),
      .wr_data(dist_wr_data),
      .rd_en  (dist_a_rd_en),
      .rd_addr(dist_a_addr),
      .rd_data(dist_a_q)
   );

   bfsp_ram #(
      .WIDTH(DENT_W),
      .DEPTH(MAX_VERTICES)
   ) u_dist_ram_b (
      .clock  (clock),
      .wr_en  (dist_wr_en),
      .wr_addr(dist_wr_addr),
      .wr_data(dist_wr_data),
      .rd_en  (cmd.dist_rd),
      .rd_addr(VIDX_W'(e_to)),
      .rd_data(dist_b_q)
   );

   // Status back to the controller
   assign sts.start_req   = accept & req_data.last_edge;
   assign sts.nv_zero     = (vcount_ff == '0);
   assign sts.vidx_last   = (CW'(vidx_ff) == CW'(nv_ff) - CW'(1));
   assign sts.edges_empty = (loaded_ff == '0);
   assign sts.edge_last   = (CNT_W'(eidx_ff) + CNT_W'(1) == loaded_ff);
   assign sts.pass_check  = ~apply;
   assign sts.rsp_free    = ~rsp_valid_ff | ~rsp_stall;

   // Next values of the counters and flags
   always_comb begin
      loaded_in    = loaded_ff;
      ovf_in       = ovf_ff;
      vidx_in      = vidx_ff;
      eidx_in      = eidx_ff;
      pass_in      = pass_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.finish) begin
         loaded_in = '0;
         ovf_in    = 1'b0;
      end else if (accept) begin
         if (room) begin
            loaded_in = loaded_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.start) begin
         vidx_in = '0;
      end else if (cmd.clr_write || cmd.out_load) begin
         vidx_in = sts.vidx_last ? '0 : vidx_ff + VIDX_W'(1);
      end

      if (cmd.pass_init || cmd.pass_next) begin
         eidx_in = '0;
      end else if (cmd.relax) begin
         eidx_in = eidx_ff + EIDX_W'(1);
      end

      if (cmd.pass_init) begin
         pass_in = nv_ff - NV_W'(1);
      end else if (cmd.pass_next && apply) begin
         pass_in = pass_ff - NV_W'(1);
      end

      if (cmd.start) begin
         neg_in = 1'b0;
      end else if (cmd.relax && relax_hit && !apply) begin
         neg_in = 1'b1;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         source_ff    <= SOURCE_RESET;
         loaded_ff    <= '0;
         ovf_ff       <= 1'b0;
         vidx_ff      <= '0;
         eidx_ff      <= '0;
         pass_ff      <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VERTEX_COUNT:  vcount_ff <= csr_wdata[VCOUNT_W-1:0];
               CSR_SOURCE_VERTEX: source_ff <= csr_wdata[VERTEX_W-1:0];
               default: ;
            endcase
         end
         loaded_ff    <= loaded_in;
         ovf_ff       <= ovf_in;
         vidx_ff      <= vidx_in;
         eidx_ff      <= eidx_in;
         pass_ff      <= pass_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Vertex count latched for the whole run; result beat register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         nv_ff <= nv_in;
      end
      if (cmd.out_load) begin
         rsp_data_ff.vertex_index   <= VERTEX_W'(vidx_ff);
         rsp_data_ff.reachable      <= dist_a_q[DIST_W];
         rsp_data_ff.distance       <= dist_a_q[DIST_W] ? dist_u : '0;
         rsp_data_ff.negative_cycle <= neg_ff;
         rsp_data_ff.edge_overflow  <= ovf_ff;
         rsp_data_ff.last_result    <= sts.vidx_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/bellman_ford_shortest_paths.sv
// Channel   Direction  Handshake           Beat
// req_      in         req_valid/req_stall  one directed weighted edge
// rsp_      out        rsp_valid/rsp_stall  one vertex result
// csr_      in         csr_valid/csr_ready  register index and write data
//
// Edges load one per cycle while the block is idle. The last edge starts a
// run (V vertices): a sweep over the distance store, then V-1 relaxing
// passes and one check pass over the stored edges (edge store read, then
// distance store read and update), skipped if no edges are stored, then the
// results, read from the distance store read port. Reset is synchronous; no
// clearing pass follows it. req_stall is high for the whole run; a stalled
// result holds only the result side.
module bellman_ford_shortest_paths #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bfsp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bfsp_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfsp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import bfsp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bfsp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .sts  (sts),
      .cmd  (cmd)
   );

   bfsp_dp #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
